// ===== src/assert_macros.svh =====
// Assertion macros used by the segment pool allocator controller.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define SAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define SAP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/sap_pkg.sv =====
// Shared types and constants for the segment pool allocator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package sap_pkg;

  localparam int unsigned SLOTS     = 4;
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ALIGN_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECURE_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECURE_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_BYTES = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_NO_SLOT     = 3'd1,
    STATUS_EXHAUSTED   = 3'd2,
    STATUS_SECURE_BUSY = 3'd3,
    STATUS_NOT_FOUND   = 3'd4
  } status_e;

  typedef struct packed {
    logic              op;
    logic              secure;
    logic [DATA_W-1:0] free_addr;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] grant_addr;
    logic [DATA_W-1:0] grant_size;
  } out_t;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// ===== src/sap_ctrl.sv =====
// Controller state machine for the segment pool allocator.
// Depends on sap_pkg and assert_macros.svh; drives commands to sap_dpath and owns the channel handshakes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sap_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  sap_pkg::sts_t sts_i,
  output sap_pkg::cmd_t cmd_o
);
  import sap_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.start  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step   = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  `SAP_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `SAP_ASSERT(a_start_scans, cmd_o.start |=> (state_q == ST_SCAN), "accepted item did not scan")
  `SAP_ASSERT(a_scan_ends, (cmd_o.step && sts_i.scan_last) |=> (state_q == ST_COMMIT),
    "scan did not end in commit")
  `SAP_ASSERT(a_result_from_commit, $rose(out_valid_o) |-> $past(state_q == ST_COMMIT),
    "result raised outside commit")

endmodule

// ===== src/sap_dpath.sv =====
// Datapath for the segment pool allocator: configuration registers, segment
// table, slot scan, grant decision and output register. Depends on sap_pkg.
`timescale 1ns / 1ps

module sap_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sap_pkg::cmd_t                   cmd_i,
  output sap_pkg::sts_t                   sts_o,
  input  sap_pkg::in_t                    in_data_i,
  output sap_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sap_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sap_pkg::DATA_W-1:0]      cfg_data_i
);
  import sap_pkg::*;

  localparam logic [DATA_W:0]   NEED_MASK = ~((DATA_W+1)'((1 << ALIGN_W) - 1));
  localparam logic [DATA_W-1:0] ADDR_MASK = ~(DATA_W'((1 << ALIGN_W) - 1));
  localparam logic [DATA_W:0]   ROUND_ADD = (DATA_W+1)'((1 << ALIGN_W) - 1);

  logic [DATA_W-1:0] pool_base_q, pool_bytes_q, secure_base_q, secure_bytes_q, request_bytes_q;

  logic [SLOTS-1:0]  slot_in_use_q, slot_in_use_d;
  logic [SLOTS-1:0]  slot_alloc_q, slot_alloc_d;
  logic [DATA_W-1:0] slot_addr_q [SLOTS];
  logic [DATA_W-1:0] slot_size_q [SLOTS];
  logic [DATA_W-1:0] used_offset_q, used_offset_d;
  logic              secure_taken_q, secure_taken_d;

  in_t               item_q;
  logic [DATA_W:0]   need_q;
  logic [DATA_W-1:0] room_q;
  logic [SLOT_W-1:0] scan_q;

  logic              reuse_hit_q, empty_hit_q, free_hit_q;
  logic [SLOT_W-1:0] empty_idx_q, free_idx_q;
  logic [SLOT_W-1:0] reuse_idx_q;
  logic [DATA_W-1:0] reuse_addr_q;

  out_t              out_q, res;
  logic              slot_write;
  logic [DATA_W-1:0] new_addr;

  logic [DATA_W:0]   need_calc;
  logic [DATA_W-1:0] room_calc;
  logic              reuse_cond, empty_cond, free_cond;

  assign need_calc = ({1'b0, request_bytes_q} + ROUND_ADD) & NEED_MASK;
  assign room_calc = (used_offset_q > pool_bytes_q) ? '0 : (pool_bytes_q - used_offset_q);
  assign new_addr  = (pool_base_q + used_offset_q) & ADDR_MASK;

  assign reuse_cond = !slot_in_use_q[scan_q] && slot_alloc_q[scan_q]
                      && ({1'b0, slot_size_q[scan_q]} == need_q);
  assign empty_cond = !slot_alloc_q[scan_q];
  assign free_cond  = slot_in_use_q[scan_q] && slot_alloc_q[scan_q]
                      && (slot_addr_q[scan_q] == item_q.free_addr);

  assign sts_o.scan_last = (scan_q == SLOT_W'(SLOTS - 1));

  always_comb begin
    res            = '{status: STATUS_OK, grant_addr: '0, grant_size: '0};
    slot_in_use_d  = slot_in_use_q;
    slot_alloc_d   = slot_alloc_q;
    used_offset_d  = used_offset_q;
    secure_taken_d = secure_taken_q;
    slot_write     = 1'b0;
    if (item_q.op == OP_FREE) begin
      if (item_q.free_addr == secure_base_q) begin
        secure_taken_d = 1'b0;
      end else if (free_hit_q) begin
        slot_in_use_d[free_idx_q] = 1'b0;
      end else begin
        res.status = STATUS_NOT_FOUND;
      end
    end else if (item_q.secure) begin
      if (secure_taken_q) begin
        res.status = STATUS_SECURE_BUSY;
      end else begin
        secure_taken_d = 1'b1;
        res.grant_addr = secure_base_q;
        res.grant_size = secure_bytes_q;
      end
    end else if (reuse_hit_q) begin
      slot_in_use_d[reuse_idx_q] = 1'b1;
      res.grant_addr             = reuse_addr_q;
      res.grant_size             = request_bytes_q;
    end else if (!empty_hit_q) begin
      res.status = STATUS_NO_SLOT;
    end else if ({1'b0, room_q} < need_q) begin
      res.status = STATUS_EXHAUSTED;
    end else begin
      slot_write                 = 1'b1;
      slot_in_use_d[empty_idx_q] = 1'b1;
      slot_alloc_d[empty_idx_q]  = 1'b1;
      used_offset_d              = used_offset_q + need_q[DATA_W-1:0];
      res.grant_addr             = new_addr;
      res.grant_size             = request_bytes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q     <= '0;
      pool_bytes_q    <= '0;
      secure_base_q   <= '0;
      secure_bytes_q  <= '0;
      request_bytes_q <= '0;
      slot_in_use_q   <= '0;
      slot_alloc_q    <= '0;
      used_offset_q   <= '0;
      secure_taken_q  <= 1'b0;
      scan_q          <= '0;
      reuse_hit_q     <= 1'b0;
      empty_hit_q     <= 1'b0;
      free_hit_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_BASE:     pool_base_q     <= cfg_data_i;
          CFG_POOL_BYTES:    pool_bytes_q    <= cfg_data_i;
          CFG_SECURE_BASE:   secure_base_q   <= cfg_data_i;
          CFG_SECURE_BYTES:  secure_bytes_q  <= cfg_data_i;
          CFG_REQUEST_BYTES: request_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        scan_q      <= '0;
        reuse_hit_q <= 1'b0;
        empty_hit_q <= 1'b0;
        free_hit_q  <= 1'b0;
      end else if (cmd_i.step) begin
        if (!sts_o.scan_last) scan_q <= scan_q + 1'b1;
        if (!reuse_hit_q && reuse_cond) reuse_hit_q <= 1'b1;
        if (!empty_hit_q && empty_cond) empty_hit_q <= 1'b1;
        if (!free_hit_q && free_cond)   free_hit_q  <= 1'b1;
      end
      if (cmd_i.commit) begin
        slot_in_use_q  <= slot_in_use_d;
        slot_alloc_q   <= slot_alloc_d;
        used_offset_q  <= used_offset_d;
        secure_taken_q <= secure_taken_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= in_data_i;
      need_q <= need_calc;
      room_q <= room_calc;
    end
    if (cmd_i.step) begin
      if (!reuse_hit_q && reuse_cond) begin
        reuse_idx_q  <= scan_q;
        reuse_addr_q <= slot_addr_q[scan_q];
      end
      if (!empty_hit_q && empty_cond) empty_idx_q <= scan_q;
      if (!free_hit_q && free_cond)   free_idx_q  <= scan_q;
    end
    if (cmd_i.commit) begin
      out_q <= res;
      if (slot_write) begin
        slot_addr_q[empty_idx_q] <= new_addr;
        slot_size_q[empty_idx_q] <= need_q[DATA_W-1:0];
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== src/segment_pool_allocator.sv =====
// Segment pool allocator: one transaction in, one result out.
// An accepted transaction scans the slots (one slot scanned per cycle), then commits once the
// output register is free; in_stall_o stays high until then, so transactions never overlap.
// A finished result waits in the output register while the next transaction is taken.
// Asynchronous active-low reset clears the slot flags, pool offset, secure flag and
// configuration registers; no clearing pass is needed.
`timescale 1ns / 1ps

module segment_pool_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sap_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sap_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sap_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sap_pkg::DATA_W-1:0]      cfg_data_i
);
  import sap_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sap_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

// ===== tb/segment_pool_allocator_tb.sv =====
// Self-checking testbench for segment_pool_allocator: directed and random transactions,
// with predicted grants compared against the block's results under random idling.
// Depends on sap_pkg and the segment_pool_allocator RTL.
`timescale 1ns / 1ps

module segment_pool_allocator_tb;
  import sap_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam logic [DATA_W:0]      GRAIN_MASK   = (33'd1 << ALIGN_W) - 33'd1;
  localparam int                   PHASES       = 60;
  localparam int                   PHASE_ITEMS  = 30;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_t                 out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  logic [DATA_W-1:0] cfg_pool_base;
  logic [DATA_W-1:0] cfg_pool_bytes;
  logic [DATA_W-1:0] cfg_secure_base;
  logic [DATA_W-1:0] cfg_secure_bytes;
  logic [DATA_W-1:0] cfg_request_bytes;

  logic              seg_busy  [SLOTS];
  logic              seg_owned [SLOTS];
  logic [DATA_W-1:0] seg_base  [SLOTS];
  logic [DATA_W-1:0] seg_len   [SLOTS];
  logic [DATA_W-1:0] pool_used;
  logic              secure_held;

  out_t pending_grants[$];
  int   err_count;
  int   sent_count;
  int   reg_writes;
  int   status_tally [5];
  int   stall_left;
  bit   stall_on;
  bit   gaps_on;

  segment_pool_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic out_t predict_grant(input in_t req);
    out_t        res;
    logic [DATA_W:0] need;
    logic [DATA_W:0] room;
    int          hit;
    int          vacant;
    res = '0;
    res.status = STATUS_OK;
    hit = -1;
    vacant = -1;
    if (req.op == OP_FREE) begin
      if (req.free_addr == cfg_secure_base) begin
        secure_held = 1'b0;
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && seg_busy[i] && seg_owned[i] && seg_base[i] == req.free_addr) hit = i;
        if (hit < 0) res.status = STATUS_NOT_FOUND;
        else seg_busy[hit] = 1'b0;
      end
    end else if (req.secure) begin
      if (secure_held) begin
        res.status = STATUS_SECURE_BUSY;
      end else begin
        secure_held = 1'b1;
        res.grant_addr = cfg_secure_base;
        res.grant_size = cfg_secure_bytes;
      end
    end else begin
      need = ({1'b0, cfg_request_bytes} + GRAIN_MASK) & ~GRAIN_MASK;
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && !seg_busy[i] && seg_owned[i] && {1'b0, seg_len[i]} == need) hit = i;
      for (int i = 0; i < SLOTS; i++)
        if (vacant < 0 && !seg_owned[i]) vacant = i;
      room = (pool_used > cfg_pool_bytes) ? '0 : {1'b0, cfg_pool_bytes - pool_used};
      if (hit >= 0) begin
        seg_busy[hit] = 1'b1;
        res.grant_addr = seg_base[hit];
        res.grant_size = cfg_request_bytes;
      end else if (vacant < 0) begin
        res.status = STATUS_NO_SLOT;
      end else if (room < need) begin
        res.status = STATUS_EXHAUSTED;
      end else begin
        seg_busy[vacant]  = 1'b1;
        seg_owned[vacant] = 1'b1;
        seg_base[vacant]  = (cfg_pool_base + pool_used) & ~GRAIN_MASK[DATA_W-1:0];
        seg_len[vacant]   = need[DATA_W-1:0];
        pool_used         = pool_used + need[DATA_W-1:0];
        res.grant_addr    = seg_base[vacant];
        res.grant_size    = cfg_request_bytes;
      end
    end
    status_tally[int'(res.status)]++;
    return res;
  endfunction

  function automatic in_t make_request(input logic op, input logic sec,
                                       input logic [DATA_W-1:0] addr);
    in_t req;
    req.op = op;
    req.secure = sec;
    req.free_addr = addr;
    return req;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return $urandom;
  endfunction

  task automatic send_request(input in_t req);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = req;
    do @(posedge clk_i); while (in_stall_o);
    pending_grants.push_back(predict_grant(req));
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // hold off until every outstanding transaction has completed
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    reg_writes++;
    case (idx)
      CFG_POOL_BASE:     cfg_pool_base = val;
      CFG_POOL_BYTES:    cfg_pool_bytes = val;
      CFG_SECURE_BASE:   cfg_secure_base = val;
      CFG_SECURE_BYTES:  cfg_secure_bytes = val;
      CFG_REQUEST_BYTES: cfg_request_bytes = val;
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall_i = 1'b1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result: status %0d addr %h size %h",
               out_data_o.status, out_data_o.grant_addr, out_data_o.grant_size);
        err_count++;
      end else begin
        want = pending_grants.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          err_count++;
        end
        if (out_data_o.grant_addr !== want.grant_addr) begin
          $error("grant_addr: expected %h, got %h", want.grant_addr, out_data_o.grant_addr);
          err_count++;
        end
        if (out_data_o.grant_size !== want.grant_size) begin
          $error("grant_size: expected %h, got %h", want.grant_size, out_data_o.grant_size);
          err_count++;
        end
      end
    end
  end

  // defaults all zero: normal and secure grants at address zero, then a busy secure retry and two frees
  task automatic test_zero_grant();
    send_request(make_request(OP_ALLOC, 1'b0, 32'hFFFF_FFFF));
    send_request(make_request(OP_ALLOC, 1'b1, 32'h0));
    send_request(make_request(OP_ALLOC, 1'b1, 32'h0));
    send_request(make_request(OP_FREE, 1'b0, 32'h0));
    send_request(make_request(OP_FREE, 1'b1, 32'h0));
  endtask

  task automatic test_pool_wrap();
    drain_results();
    write_reg(CFG_POOL_BASE, 32'hFFFF_FF00);
    write_reg(CFG_POOL_BYTES, 32'hFFFF_FFFF);
    write_reg(CFG_REQUEST_BYTES, 32'd1);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_REQUEST_BYTES, 32'd600);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
  endtask

  task automatic test_exhaustion();
    drain_results();
    write_reg(CFG_POOL_BYTES, 32'd100);
    write_reg(CFG_REQUEST_BYTES, 32'd1);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_POOL_BYTES, 32'hFFFF_FFFF);
    write_reg(CFG_REQUEST_BYTES, 32'hFFFF_FFFF);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_REQUEST_BYTES, 32'hFFFF_FE00);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_POOL_BYTES, 32'd3583);
    write_reg(CFG_REQUEST_BYTES, 32'd2048);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_POOL_BYTES, 32'd3584);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
  endtask

  task automatic test_no_slot();
    drain_results();
    write_reg(CFG_REQUEST_BYTES, 32'd4096);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_POOL_BYTES, 32'd0);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_REQUEST_BYTES, 32'hFFFF_FFFF);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
  endtask

  task automatic test_secure();
    drain_results();
    write_reg(CFG_SECURE_BASE, 32'hFFFF_FFFF);
    write_reg(CFG_SECURE_BYTES, 32'hFFFF_FFFF);
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    send_request(make_request(OP_ALLOC, 1'b1, 32'h5A5A_A5A5));
    send_request(make_request(OP_ALLOC, 1'b1, 32'h0));
    send_request(make_request(OP_FREE, 1'b1, 32'hFFFF_FFFF));
    send_request(make_request(OP_FREE, 1'b0, 32'h1234_5678));
    drain_results();
    write_reg(CFG_SECURE_BASE, 32'h0000_0400);
    write_reg(CFG_SECURE_BYTES, 32'd1);
    send_request(make_request(OP_FREE, 1'b0, 32'h0000_0400));
  endtask

  task automatic test_reuse();
    drain_results();
    write_reg(CFG_SECURE_BASE, 32'h8000_0000);
    write_reg(CFG_REQUEST_BYTES, 32'd1500);
    send_request(make_request(OP_FREE, 1'b0, 32'h0000_0400));
    send_request(make_request(OP_FREE, 1'b0, 32'h0000_0400));
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    send_request(make_request(OP_FREE, 1'b0, 32'h0));
    send_request(make_request(OP_FREE, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_REQUEST_BYTES, 32'd0);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
    drain_results();
    write_reg(CFG_REQUEST_BYTES, 32'd513);
    send_request(make_request(OP_ALLOC, 1'b0, 32'h0));
  endtask

  task automatic test_random();
    int          kind;
    int          pick;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] len;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      stall_on = (ph % 5 != 0);
      gaps_on = (ph % 4 != 1);
      pick = $urandom_range(0, 99);
      len = seg_len[$urandom_range(0, SLOTS - 1)];
      if (pick < 75) write_reg(CFG_REQUEST_BYTES, (len == 0) ? '0 : len - $urandom_range(0, 511));
      else write_reg(CFG_REQUEST_BYTES, pick_word());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_POOL_BASE, pick_word());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_POOL_BYTES, pick_word());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SECURE_BYTES, pick_word());
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 2) == 0)
          write_reg(CFG_SECURE_BASE, seg_base[$urandom_range(0, SLOTS - 1)]);
        else write_reg(CFG_SECURE_BASE, pick_word());
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          send_request(make_request(OP_ALLOC, 1'b0, $urandom));
        end else if (kind < 55) begin
          send_request(make_request(OP_ALLOC, 1'b1, $urandom));
        end else begin
          pick = $urandom_range(0, 99);
          addr = $urandom;
          if (pick < 60) begin
            kind = $urandom_range(0, SLOTS - 1);
            if (seg_owned[kind]) addr = seg_base[kind];
          end else if (pick < 75) begin
            addr = cfg_secure_base;
          end
          send_request(make_request(OP_FREE, 1'($urandom_range(0, 1)), addr));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    cfg_pool_base = '0;
    cfg_pool_bytes = '0;
    cfg_secure_base = '0;
    cfg_secure_bytes = '0;
    cfg_request_bytes = '0;
    for (int i = 0; i < SLOTS; i++) begin
      seg_busy[i] = 1'b0;
      seg_owned[i] = 1'b0;
      seg_base[i] = '0;
      seg_len[i] = '0;
    end
    pool_used = '0;
    secure_held = 1'b0;
    err_count = 0;
    sent_count = 0;
    reg_writes = 0;
    stall_left = 0;
    stall_on = 1'b1;
    gaps_on = 1'b1;
    for (int i = 0; i < 5; i++) status_tally[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_grant();
    test_pool_wrap();
    test_exhaustion();
    test_no_slot();
    test_secure();
    test_reuse();
    test_random();

    drain_results();
    repeat (SLOTS * 4) @(posedge clk_i);
    $display("Covered %0d transactions over %0d register writes: %0d ok, %0d no slot,",
             sent_count, reg_writes, status_tally[0], status_tally[1]);
    $display("  %0d pool exhausted, %0d secure busy, %0d address not found",
             status_tally[2], status_tally[3], status_tally[4]);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", pending_grants.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== segment_pool_allocator.f =====
+incdir+src
src/sap_pkg.sv
src/sap_ctrl.sv
src/sap_dpath.sv
src/segment_pool_allocator.sv
tb/segment_pool_allocator_tb.sv
